@@ rtl/core/wsfd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and codes of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int OPCODE_W  = 4;
    localparam int PINGS_W   = 8;
    localparam int MAXLEN_W  = 31;
    localparam int CFG_IDX_W = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PING  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

    // error codes
    localparam logic ERR_LENGTH = 1'b0;
    localparam logic ERR_PINGS  = 1'b1;

    // commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    // frame opcodes
    localparam logic [OPCODE_W-1:0] OP_CLOSE = 4'h8;
    localparam logic [OPCODE_W-1:0] OP_PING  = 4'h9;
    localparam logic [OPCODE_W-1:0] OP_PONG  = 4'hA;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PING_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PINGS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd2;

    // configuration reset values
    localparam logic [PINGS_W-1:0]  RST_MAX_PINGS = 8'd5;
    localparam logic [MAXLEN_W-1:0] RST_MAX_LEN   = 31'h7FFF_0000;

    typedef struct packed {
        logic                ping_en;
        logic [PINGS_W-1:0]  max_pings;
        logic [MAXLEN_W-1:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [OPCODE_W-1:0] frame_opcode;
        logic                fin_flag;
        logic                compressed_flag;
        logic                to_pong_reply;
        logic                last_of_frame;
        logic                closes;
        logic                error_code;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/core/wsfd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_if
// Valid/ready channels of the deframer: input items, results, config writes.
// ----------------------------------------------------------------------------
interface wsfd_in_if
    import wsfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface wsfd_out_if
    import wsfd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [OPCODE_W-1:0] frame_opcode;
    logic                fin_flag;
    logic                compressed_flag;
    logic                to_pong_reply;
    logic                last_of_frame;
    logic                closes;
    logic                error_code;

    modport source (
        output valid, output kind, output data_byte, output frame_opcode,
        output fin_flag, output compressed_flag, output to_pong_reply,
        output last_of_frame, output closes, output error_code, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input frame_opcode,
        input fin_flag, input compressed_flag, input to_pong_reply,
        input last_of_frame, input closes, input error_code, output ready
    );
endinterface

interface wsfd_cfg_if
    import wsfd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MAXLEN_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/websocket_frame_deframer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Receive-side websocket frame deframer with ping keepalive.
// ----------------------------------------------------------------------------
// One input item (link byte or idle tick) is taken every cycle while the skid
// entry is empty; its result, if any, is registered in the output register,
// or in the skid entry while the sink stalls. The rate is set by the parser's
// combinational parse update and by the output register with a one-entry
// skid buffer: input ready drops only while the skid entry holds a result, so
// a stalled sink costs one item of slack before the input side stalls. The
// configuration writes are always ready and take effect on the next item.
module websocket_frame_deframer_core
    import wsfd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wsfd_in_if.sink     i_rx,
    wsfd_out_if.source  o_res,
    wsfd_cfg_if.sink    i_cfg
);

    t_cfg    r_cfg;
    t_result res;
    logic    res_valid;
    logic    accept;
    logic    out_take;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ping_en   <= 1'b0;
            r_cfg.max_pings <= RST_MAX_PINGS;
            r_cfg.max_len   <= RST_MAX_LEN;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PING_EN:   r_cfg.ping_en   <= i_cfg.data[0];
                CFG_MAX_PINGS: r_cfg.max_pings <= i_cfg.data[PINGS_W-1:0];
                CFG_MAX_LEN:   r_cfg.max_len   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign i_rx.ready = !r_skid_valid;
    assign accept     = i_rx.valid && i_rx.ready;
    assign out_take   = r_out_valid && o_res.ready;

    wsfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_rx.command),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= res;
            end
        end else if (accept && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.kind            = r_out.kind;
    assign o_res.data_byte       = r_out.data_byte;
    assign o_res.frame_opcode    = r_out.frame_opcode;
    assign o_res.fin_flag        = r_out.fin_flag;
    assign o_res.compressed_flag = r_out.compressed_flag;
    assign o_res.to_pong_reply   = r_out.to_pong_reply;
    assign o_res.last_of_frame   = r_out.last_of_frame;
    assign o_res.closes          = r_out.closes;
    assign o_res.error_code      = r_out.error_code;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready && accept && res_valid) |=> r_skid_valid)
        else $error("result lost while output stalled");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && o_res.ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry did not move to output register");

endmodule
`default_nettype wire

@@ rtl/core/wsfd_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame header parse, payload unmask and ping keepalive, one transfer a cycle.
// ----------------------------------------------------------------------------
module wsfd_parser
    import wsfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_command,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire t_cfg              i_cfg,
    output logic                   o_res_valid,
    output t_result                o_res
);

    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_EXT   = 3'd2;
    localparam logic [2:0] PH_MASK  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [3:0] CNT_EXT16 = 4'd2;
    localparam logic [3:0] CNT_EXT64 = 4'd8;
    localparam logic [3:0] CNT_MASK  = 4'd4;

    logic [2:0]          r_phase,   n_phase;
    logic [BYTE_W-1:0]   r_first,   n_first;
    logic [3:0]          r_cnt,     n_cnt;
    logic [MAXLEN_W-1:0] r_len,     n_len;
    logic                r_big,     n_big;
    logic                r_mask,    n_mask;
    logic [31:0]         r_key,     n_key;
    logic [1:0]          r_lane,    n_lane;
    logic [PINGS_W-1:0]  r_pings,   n_pings;
    logic                r_stopped, n_stopped;

    logic [OPCODE_W-1:0] opcode;
    logic                filtered;
    logic                lk;
    logic [MAXLEN_W-1:0] lk_len;
    logic                lk_big;
    logic                lk_mask;
    logic                sp;
    logic [MAXLEN_W-1:0] sp_len;
    logic                fr;
    logic                fr_last;
    logic [KIND_W-1:0]   fr_kind;
    logic [BYTE_W-1:0]   fr_data;
    logic [BYTE_W-1:0]   key_byte;

    assign opcode   = r_first[OPCODE_W-1:0];
    assign filtered = i_cfg.ping_en && (opcode == OP_PONG);

    always_comb begin
        case (r_lane)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_big       = r_big;
        n_mask      = r_mask;
        n_key       = r_key;
        n_lane      = r_lane;
        n_pings     = r_pings;
        n_stopped   = r_stopped;
        lk          = 1'b0;
        lk_len      = '0;
        lk_big      = 1'b0;
        lk_mask     = 1'b0;
        sp          = 1'b0;
        sp_len      = '0;
        fr          = 1'b0;
        fr_last     = 1'b0;
        fr_kind     = KIND_BYTE;
        fr_data     = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!r_stopped) begin
            if (i_command == CMD_BYTE) begin
                n_pings = '0;
                case (r_phase)
                    PH_LEN: begin
                        n_mask = i_rx_byte[7];
                        n_key  = '0;
                        n_lane = '0;
                        n_big  = 1'b0;
                        n_cnt  = '0;
                        if (i_rx_byte[6:0] < LEN_EXT16) begin
                            n_len   = {{(MAXLEN_W-7){1'b0}}, i_rx_byte[6:0]};
                            lk      = 1'b1;
                            lk_len  = n_len;
                            lk_mask = i_rx_byte[7];
                        end else begin
                            n_len   = '0;
                            n_cnt   = (i_rx_byte[6:0] == LEN_EXT16) ? CNT_EXT16 : CNT_EXT64;
                            n_phase = PH_EXT;
                        end
                    end
                    PH_EXT: begin
                        n_len = {r_len[MAXLEN_W-BYTE_W-1:0], i_rx_byte};
                        n_big = r_big || (r_len[MAXLEN_W-1:MAXLEN_W-BYTE_W] != '0);
                        n_cnt = r_cnt - 4'd1;
                        if (r_cnt == 4'd1) begin
                            lk      = 1'b1;
                            lk_len  = n_len;
                            lk_big  = n_big;
                            lk_mask = r_mask;
                        end
                    end
                    PH_MASK: begin
                        n_key = {r_key[23:0], i_rx_byte};
                        n_cnt = r_cnt - 4'd1;
                        if (r_cnt == 4'd1) begin
                            sp     = 1'b1;
                            sp_len = r_len;
                        end
                    end
                    PH_DATA: begin
                        fr_last = (r_len == {{(MAXLEN_W-1){1'b0}}, 1'b1});
                        n_len   = r_len - {{(MAXLEN_W-1){1'b0}}, 1'b1};
                        n_lane  = r_lane + 2'd1;
                        if (fr_last) begin
                            n_phase = PH_FIRST;
                        end
                        fr      = !filtered;
                        fr_kind = KIND_BYTE;
                        fr_data = i_rx_byte ^ key_byte;
                    end
                    default: begin
                        n_first = i_rx_byte;
                        n_phase = PH_LEN;
                    end
                endcase

                if (lk) begin
                    if (lk_big || (lk_len > i_cfg.max_len)) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_LENGTH;
                        n_stopped        = 1'b1;
                    end else if (lk_mask) begin
                        n_phase = PH_MASK;
                        n_cnt   = CNT_MASK;
                    end else begin
                        sp     = 1'b1;
                        sp_len = lk_len;
                    end
                end

                if (sp) begin
                    n_lane = '0;
                    if (sp_len == '0) begin
                        n_phase = PH_FIRST;
                        fr      = !filtered;
                        fr_kind = KIND_EMPTY;
                        fr_last = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end

                if (fr) begin
                    o_res_valid           = 1'b1;
                    o_res.kind            = fr_kind;
                    o_res.data_byte       = fr_data;
                    o_res.frame_opcode    = opcode;
                    o_res.fin_flag        = r_first[7];
                    o_res.compressed_flag = r_first[6];
                    o_res.to_pong_reply   = i_cfg.ping_en && (opcode == OP_PING);
                    o_res.last_of_frame   = fr_last;
                    o_res.closes          = fr_last && (opcode == OP_CLOSE);
                    if (fr_last && (opcode == OP_CLOSE)) begin
                        n_stopped = 1'b1;
                    end
                end
            end else begin
                if (r_pings > i_cfg.max_pings) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_PINGS;
                    n_stopped        = 1'b1;
                end else if (i_cfg.ping_en) begin
                    if (r_pings != {PINGS_W{1'b1}}) begin
                        n_pings = r_pings + {{(PINGS_W-1){1'b0}}, 1'b1};
                    end
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_PING;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FIRST;
            r_first   <= '0;
            r_cnt     <= '0;
            r_len     <= '0;
            r_big     <= 1'b0;
            r_mask    <= 1'b0;
            r_key     <= '0;
            r_lane    <= '0;
            r_pings   <= '0;
            r_stopped <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_first   <= n_first;
            r_cnt     <= n_cnt;
            r_len     <= n_len;
            r_big     <= n_big;
            r_mask    <= n_mask;
            r_key     <= n_key;
            r_lane    <= n_lane;
            r_pings   <= n_pings;
            r_stopped <= n_stopped;
        end
    end

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared");

    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_res_valid && (o_res.kind == KIND_ERROR)) |=> r_stopped)
        else $error("error transfer did not stop the connection");

    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_len != '0))
        else $error("payload phase with no bytes left");

endmodule
`default_nettype wire

@@ dv/websocket_frame_deframer_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core_test
// Self-checking bench for the websocket frame deframer. A queue-fed driver
// sends link bytes and idle ticks with random gaps, the result sink stalls at
// random, and an in-bench parser model predicts every result. Directed frames
// come first, then random well-formed frames over several register settings,
// and the run closes by ending the connection one of three ways.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core_test;
    import wsfd_pkg::*;

    localparam int          RESET_CYCLES    = 12;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          ITEMS_PER_PHASE = 190;
    localparam int unsigned CYCLE_LIMIT     = 600000;

    localparam logic [6:0] LEN16_MARK = 7'd126;
    localparam logic [6:0] LEN64_MARK = 7'd127;

    localparam logic [7:0] DIRECTED_A [16] = '{
        8'h81, 8'h83, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF,
        8'h5A, 8'hC2, 8'h00, 8'h0A, 8'h7E, 8'h00, 8'h01, 8'h3C
    };
    localparam logic [7:0] DIRECTED_B [5] = '{8'h89, 8'h01, 8'h77, 8'h8A, 8'h00};

    typedef enum logic [2:0] {PH_FIRST, PH_LEN, PH_EXT, PH_MASK, PH_DATA} t_phase;
    typedef enum int {LEN_SHORT, LEN_MID, LEN_LONG} t_len_form;
    typedef enum int {END_CLOSE, END_LENGTH, END_PINGS} t_end_mode;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] rx_byte;
    } t_item;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 rx_valid  = 1'b0;
    logic                 rx_cmd    = CMD_BYTE;
    logic [BYTE_W-1:0]    rx_data   = '0;
    logic                 res_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PING_EN;
    logic [MAXLEN_W-1:0]  cfg_data  = '0;

    wsfd_in_if  rx_ch();
    wsfd_out_if res_ch();
    wsfd_cfg_if cfg_ch();

    assign rx_ch.valid   = rx_valid;
    assign rx_ch.command = rx_cmd;
    assign rx_ch.rx_byte = rx_data;
    assign res_ch.ready  = res_ready;
    assign cfg_ch.valid  = cfg_valid;
    assign cfg_ch.index  = cfg_index;
    assign cfg_ch.data   = cfg_data;

    websocket_frame_deframer_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // parser model state
    t_phase              phase         = PH_FIRST;
    logic [7:0]          hdr_byte0     = '0;
    logic [3:0]          hdr_left      = '0;
    logic [63:0]         plen          = '0;
    logic                masked        = 1'b0;
    logic [31:0]         mkey          = '0;
    logic [30:0]         pidx          = '0;
    logic [PINGS_W-1:0]  ping_debt     = '0;
    logic                link_down     = 1'b0;
    logic                cfg_ping_en   = 1'b0;
    logic [PINGS_W-1:0]  cfg_max_pings = RST_MAX_PINGS;
    logic [MAXLEN_W-1:0] cfg_max_len   = RST_MAX_LEN;

    t_item       link_q[$];
    t_result     due_results[$];
    int unsigned errors      = 0;
    int unsigned checked     = 0;
    int unsigned items_taken = 0;
    int unsigned queued      = 0;
    int unsigned phases      = 0;
    int unsigned cycles      = 0;
    int unsigned gen_pings   = 0;
    bit          tick_noise  = 1'b0;
    bit          no_gaps     = 1'b0;
    bit          rx_took     = 1'b0;
    int unsigned rx_wait     = 0;
    int unsigned res_hold    = 0;

    function automatic bit pong_drop();
        return cfg_ping_en && hdr_byte0[3:0] == OP_PONG;
    endfunction

    function automatic bit frame_result(output t_result r, input logic [KIND_W-1:0] kind,
                                        input logic [7:0] d, input bit last);
        r                 = '0;
        r.kind            = kind;
        r.data_byte       = d;
        r.frame_opcode    = hdr_byte0[3:0];
        r.fin_flag        = hdr_byte0[7];
        r.compressed_flag = hdr_byte0[6];
        r.to_pong_reply   = cfg_ping_en && hdr_byte0[3:0] == OP_PING;
        r.last_of_frame   = last;
        r.closes          = last && hdr_byte0[3:0] == OP_CLOSE;
        if (r.closes) begin
            link_down = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic bit payload_begin(output t_result r);
        r    = '0;
        pidx = '0;
        if (plen == 64'd0) begin
            phase = PH_FIRST;
            if (pong_drop()) begin
                return 1'b0;
            end
            return frame_result(r, KIND_EMPTY, 8'h00, 1'b1);
        end
        phase = PH_DATA;
        return 1'b0;
    endfunction

    function automatic bit length_done(output t_result r);
        r = '0;
        if (plen > {33'd0, cfg_max_len}) begin
            r.kind       = KIND_ERROR;
            r.error_code = ERR_LENGTH;
            link_down    = 1'b1;
            return 1'b1;
        end
        if (masked) begin
            phase    = PH_MASK;
            hdr_left = 4'd4;
            return 1'b0;
        end
        return payload_begin(r);
    endfunction

    // advances the parser by one link item, returns 1 when a result is due
    function automatic bit deframe_step(input logic cmd, input logic [7:0] b,
                                        output t_result r);
        logic [7:0] d;
        bit         last;
        bit         hit;
        r   = '0;
        hit = 1'b0;
        if (link_down) begin
            return 1'b0;
        end
        if (cmd == CMD_IDLE) begin
            if (ping_debt > cfg_max_pings) begin
                r.kind       = KIND_ERROR;
                r.error_code = ERR_PINGS;
                link_down    = 1'b1;
                return 1'b1;
            end
            if (!cfg_ping_en) begin
                return 1'b0;
            end
            if (ping_debt != 8'hFF) begin
                ping_debt++;
            end
            r.kind = KIND_PING;
            return 1'b1;
        end
        ping_debt = '0;
        case (phase)
            PH_LEN: begin
                masked   = b[7];
                mkey     = '0;
                pidx     = '0;
                plen     = '0;
                hdr_left = '0;
                if (b[6:0] < LEN16_MARK) begin
                    plen = {57'd0, b[6:0]};
                    hit  = length_done(r);
                end else begin
                    hdr_left = (b[6:0] == LEN16_MARK) ? 4'd2 : 4'd8;
                    phase    = PH_EXT;
                end
            end
            PH_EXT: begin
                plen = {plen[55:0], b};
                hdr_left--;
                if (hdr_left == 4'd0) begin
                    hit = length_done(r);
                end
            end
            PH_MASK: begin
                mkey = {mkey[23:0], b};
                hdr_left--;
                if (hdr_left == 4'd0) begin
                    hit = payload_begin(r);
                end
            end
            PH_DATA: begin
                d    = b ^ mkey[8*(3 - pidx[1:0]) +: 8];
                last = ({33'd0, pidx} + 64'd1) >= plen;
                pidx++;
                if (last) begin
                    phase = PH_FIRST;
                end
                if (!pong_drop()) begin
                    hit = frame_result(r, KIND_BYTE, d, last);
                end
            end
            default: begin
                hdr_byte0 = b;
                phase     = PH_LEN;
            end
        endcase
        return hit;
    endfunction

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if ($urandom_range(0, 255) == 0) begin
            no_gaps <= !no_gaps;
        end
        if (cycles == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // link item driver
    always @(negedge clk) begin
        t_item nxt;
        if (!rst_n) begin
            rx_valid <= 1'b0;
        end else if (!rx_valid || rx_took) begin
            if (rx_wait != 0) begin
                rx_wait  <= rx_wait - 1;
                rx_valid <= 1'b0;
            end else if (link_q.size() != 0) begin
                nxt = link_q.pop_front();
                rx_valid <= 1'b1;
                rx_cmd   <= nxt.command;
                rx_data  <= nxt.rx_byte;
                if (!no_gaps && $urandom_range(0, 3) == 0) begin
                    rx_wait <= pick_gap();
                end
            end else begin
                rx_valid <= 1'b0;
            end
        end
    end

    // result sink backpressure
    always @(negedge clk) begin
        if (res_hold != 0) begin
            res_hold  <= res_hold - 1;
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 5) == 0) begin
                res_hold <= pick_gap();
            end
        end
    end

    // monitor: config writes, accepted items, delivered results
    always @(posedge clk) begin
        t_result want;
        rx_took <= rx_valid && rx_ch.ready;
        if (rst_n) begin
            if (cfg_valid && cfg_ch.ready) begin
                case (cfg_index)
                    CFG_PING_EN:   cfg_ping_en   = cfg_data[0];
                    CFG_MAX_PINGS: cfg_max_pings = cfg_data[PINGS_W-1:0];
                    CFG_MAX_LEN:   cfg_max_len   = cfg_data;
                    default: ;
                endcase
            end
            if (rx_valid && rx_ch.ready) begin
                items_taken++;
                if (deframe_step(rx_cmd, rx_data, want)) begin
                    due_results.push_back(want);
                end
            end
            if (res_ch.valid && res_ready) begin
                if (due_results.size() == 0) begin
                    report($sformatf("unexpected result of kind %0d", res_ch.kind));
                end else begin
                    want = due_results.pop_front();
                    checked++;
                    check_field("kind", res_ch.kind, want.kind);
                    check_field("data_byte", res_ch.data_byte, want.data_byte);
                    check_field("frame_opcode", res_ch.frame_opcode, want.frame_opcode);
                    check_field("fin_flag", res_ch.fin_flag, want.fin_flag);
                    check_field("compressed_flag", res_ch.compressed_flag,
                                want.compressed_flag);
                    check_field("to_pong_reply", res_ch.to_pong_reply, want.to_pong_reply);
                    check_field("last_of_frame", res_ch.last_of_frame, want.last_of_frame);
                    check_field("closes", res_ch.closes, want.closes);
                    check_field("error_code", res_ch.error_code, want.error_code);
                end
            end
        end
    end

    task automatic push_item(input logic cmd, input logic [7:0] b);
        link_q.push_back('{command: cmd, rx_byte: b});
        queued++;
    endtask

    task automatic push_tick();
        push_item(CMD_IDLE, 8'($urandom));
        if (cfg_ping_en && gen_pings < 255) begin
            gen_pings++;
        end
    endtask

    // idle ticks slip in between bytes only while they cannot end the link
    task automatic push_byte(input logic [7:0] b);
        if (tick_noise && $urandom_range(0, 7) == 0 && gen_pings <= cfg_max_pings) begin
            push_tick();
        end
        push_item(CMD_BYTE, b);
        gen_pings = 0;
    endtask

    task automatic push_header(input logic [7:0] first, input logic [63:0] len,
                               input logic mask_on, input t_len_form form);
        push_byte(first);
        case (form)
            LEN_SHORT: push_byte({mask_on, len[6:0]});
            LEN_MID: begin
                push_byte({mask_on, LEN16_MARK});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default: begin
                push_byte({mask_on, LEN64_MARK});
                for (int i = 7; i >= 0; i--) begin
                    push_byte(len[8*i +: 8]);
                end
            end
        endcase
        if (mask_on) begin
            repeat (4) push_byte(8'($urandom));
        end
    endtask

    task automatic push_frame(input logic [7:0] first, input int unsigned len,
                              input logic mask_on, input t_len_form form);
        push_header(first, 64'(len), mask_on, form);
        repeat (len) push_byte(8'($urandom));
    endtask

    task automatic random_frame();
        logic [3:0]  op;
        int unsigned cap;
        int unsigned len;
        t_len_form   form;
        case ($urandom_range(0, 7))
            0: op = OP_PING;
            1: op = OP_PONG;
            default: begin
                do op = 4'($urandom); while (op == OP_CLOSE);
            end
        endcase
        cap = ($urandom_range(0, 15) == 0) ? 300 : 24;
        if (cfg_max_len < cap) begin
            cap = cfg_max_len;
        end
        len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, cap);
        if (len < 126) begin
            form = t_len_form'($urandom_range(0, 2));
        end else begin
            form = $urandom_range(0, 1) ? LEN_MID : LEN_LONG;
        end
        push_frame({4'($urandom), op}, len, 1'($urandom), form);
    endtask

    task automatic drain();
        do @(posedge clk); while (link_q.size() != 0 || rx_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_send(input logic [CFG_IDX_W-1:0] idx, input logic [MAXLEN_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic set_config(input logic en, input logic [7:0] max_pings,
                              input logic [MAXLEN_W-1:0] max_len);
        drain();
        cfg_send(CFG_PING_EN, MAXLEN_W'(en));
        cfg_send(CFG_MAX_PINGS, MAXLEN_W'(max_pings));
        cfg_send(CFG_MAX_LEN, max_len);
        @(negedge clk);
        cfg_valid <= 1'b0;
        gen_pings = ping_debt;
        phases++;
    endtask

    task automatic random_phase(input logic en, input logic [7:0] max_pings,
                                input logic [MAXLEN_W-1:0] max_len);
        int unsigned start;
        set_config(en, max_pings, max_len);
        start = queued;
        while (queued - start < ITEMS_PER_PHASE) begin
            random_frame();
        end
    endtask

    initial begin
        t_end_mode           end_mode;
        string               end_desc;
        logic [MAXLEN_W-1:0] lim;
        logic [63:0]         big;
        logic [7:0]          mp;
        t_len_form           form;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: masked text, empty rsv1 marker, pong with pings off
        tick_noise = 1'b0;
        push_tick();
        foreach (DIRECTED_A[i]) begin
            push_byte(DIRECTED_A[i]);
        end
        // directed: keepalive pings, ping reply routing, pong filtering
        set_config(1'b1, 8'd1, RST_MAX_LEN);
        push_tick();
        push_tick();
        foreach (DIRECTED_B[i]) begin
            push_byte(DIRECTED_B[i]);
        end

        tick_noise = 1'b1;
        random_phase(1'b0, 8'($urandom), RST_MAX_LEN);
        random_phase(1'b1, 8'd0, '0);
        random_phase(1'b1, 8'd255, MAXLEN_W'($urandom_range(1, 300)));
        random_phase(1'b0, 8'd1, MAXLEN_W'($urandom_range(0, 50)));
        repeat (4) begin
            mp = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            case ($urandom_range(0, 2))
                0: lim = RST_MAX_LEN;
                1: lim = '0;
                default: lim = MAXLEN_W'($urandom_range(1, 400));
            endcase
            random_phase(1'($urandom), mp, lim);
        end

        // end the connection, then show that the rest is ignored
        tick_noise = 1'b0;
        end_mode = t_end_mode'($urandom_range(0, 2));
        case (end_mode)
            END_CLOSE: begin
                end_desc = "a close frame";
                set_config(1'($urandom), 8'($urandom), RST_MAX_LEN);
                push_frame({4'($urandom), OP_CLOSE}, $urandom_range(0, 3), 1'($urandom),
                           LEN_SHORT);
            end
            END_LENGTH: begin
                end_desc = "an oversized length";
                lim = MAXLEN_W'($urandom_range(0, 100));
                set_config(1'($urandom), 8'($urandom), lim);
                form = t_len_form'($urandom_range(0, 2));
                case (form)
                    LEN_SHORT: big = 64'($urandom_range(lim + 1, 125));
                    LEN_MID:   big = 64'($urandom_range(lim + 1, 65535));
                    default: begin
                        big = {$urandom, $urandom};
                        if (big <= 64'(lim)) begin
                            big = 64'(lim) + 64'($urandom_range(1, 1000));
                        end
                    end
                endcase
                push_header({4'($urandom), 4'($urandom)}, big, 1'($urandom), form);
            end
            default: begin
                end_desc = "unanswered pings";
                mp = 8'($urandom_range(0, 3));
                set_config(1'b1, mp, RST_MAX_LEN);
                push_frame(8'h81, 0, 1'b0, LEN_SHORT);
                repeat (int'(mp) + 2) push_tick();
            end
        endcase
        repeat (16) begin
            if ($urandom_range(0, 1)) begin
                push_tick();
            end else begin
                push_byte(8'($urandom));
            end
        end
        drain();

        $display("%0d link items over %0d register settings, %0d results checked",
                 items_taken, phases, checked);
        $display("connection ended by %s, later input ignored", end_desc);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
